// File: rtl/core/dmts_pkg.sv
// Dual motor turn sequencer: shared types, command and motion codes,
// and the pin pattern table. No dependencies.
`default_nettype none

package dmts_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_FORWARD   = 3'd1;
  localparam logic [2:0] CMD_BACKWARD  = 3'd2;
  localparam logic [2:0] CMD_HALT      = 3'd3;
  localparam logic [2:0] CMD_TURN_RT   = 3'd4;
  localparam logic [2:0] CMD_TURN_LT   = 3'd5;

  // Motion codes reported on the result channel
  localparam logic [2:0] MOT_FORWARD   = 3'd1;
  localparam logic [2:0] MOT_BACKWARD  = 3'd2;
  localparam logic [2:0] MOT_HALTED    = 3'd3;
  localparam logic [2:0] MOT_TURN_RT   = 3'd4;
  localparam logic [2:0] MOT_TURN_LT   = 3'd5;

  // Settle hold after reset, in ticks
  localparam logic [15:0] SETTLE_RESET = 16'd500;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TURN   = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  // One input item
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] turn_ticks;
  } item_t;

  // One result item; pins are {right_fwd, right_rev, left_fwd, left_rev}
  typedef struct packed {
    logic [3:0] pins;
    logic [2:0] motion;
    logic       ready;
    logic       rejected;
  } res_t;

  // Pin pattern for a motion code
  function automatic logic [3:0] pins_for(input logic [2:0] m);
    logic [3:0] p;
    case (m)
      MOT_FORWARD:  p = 4'b1010;
      MOT_BACKWARD: p = 4'b0101;
      MOT_TURN_RT:  p = 4'b1001;
      MOT_TURN_LT:  p = 4'b0110;
      default:      p = 4'b0000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dmts_in_reg.sv
// Dual motor turn sequencer: input register stage.
// Depends on dmts_pkg for the item type.
`default_nettype none

module dmts_in_reg
  import dmts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire item_t       in_item,
  input  wire logic        adv,        // downstream takes the held item
  output      logic        hold_valid,
  output      item_t       hold_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  // Room when empty or when the held item moves on this cycle
  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

`default_nettype wire

// File: rtl/core/dmts_ctrl.sv
// Dual motor turn sequencer: settle register, sequencer state and the
// per-item next-state logic. Depends on dmts_pkg.
`default_nettype none

module dmts_ctrl
  import dmts_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        go,         // apply item this cycle
  input  wire item_t       item,
  output      res_t        res         // state after the item
);

  localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [EXT_W-1:0] CNT_MAX_EXT = EXT_W'({COUNT_WIDTH{1'b1}});

  logic [15:0]            settle_r;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [2:0]             motion_r, motion_nxt;
  logic [2:0]             saved_r, saved_nxt;
  logic                   rej;

  logic [COUNT_WIDTH-1:0] settle_load, turn_load, cnt_dec;

  // Loaded counts saturate at the counter's top value
  function automatic logic [COUNT_WIDTH-1:0] sat(input logic [15:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return (e > CNT_MAX_EXT) ? COUNT_WIDTH'(CNT_MAX_EXT) : e[COUNT_WIDTH-1:0];
  endfunction

  assign settle_load = sat(settle_r);
  assign turn_load   = sat(item.turn_ticks);
  assign cnt_dec     = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;

  // Settle register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
    end else if (cfg_we) begin
      settle_r <= cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    motion_nxt = motion_r;
    saved_nxt  = saved_r;
    rej        = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        if (phase_r != PH_IDLE) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            if (phase_r == PH_TURN) begin
              // turn done: restore saved action, then settle
              motion_nxt = saved_r;
              cnt_nxt    = settle_load;
              phase_nxt  = (settle_load == '0) ? PH_IDLE : PH_SETTLE;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      CMD_FORWARD, CMD_BACKWARD, CMD_HALT: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          motion_nxt = item.cmd;
          cnt_nxt    = settle_load;
          phase_nxt  = (settle_load == '0) ? PH_IDLE : PH_SETTLE;
        end
      end
      CMD_TURN_RT, CMD_TURN_LT: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          saved_nxt = motion_r;
          if (turn_load == '0) begin
            // zero-length turn: ends at once, current action stays
            cnt_nxt   = settle_load;
            phase_nxt = (settle_load == '0) ? PH_IDLE : PH_SETTLE;
          end else begin
            motion_nxt = item.cmd;
            cnt_nxt    = turn_load;
            phase_nxt  = PH_TURN;
          end
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
  end

  // Result outputs
  always_comb begin
    res.pins     = pins_for(motion_nxt);
    res.motion   = motion_nxt;
    res.ready    = (phase_nxt == PH_IDLE);
    res.rejected = rej;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      motion_r <= MOT_HALTED;
      saved_r  <= MOT_HALTED;
    end else if (go) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      motion_r <= motion_nxt;
      saved_r  <= saved_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dual_motor_turn_sequencer_core.sv
// Dual motor turn sequencer top level: input stage, sequencer, result register.
// Depends on dmts_pkg, dmts_in_reg and dmts_ctrl.
//
// Usage:
//   Input channel (in_valid/in_stall, in_cmd, in_turn_ticks) carries ticks and
//   commands; a transfer happens on a clock edge with valid high and stall low.
//   Every transfer produces exactly one result transfer on the output channel
//   (out_valid/out_stall) with the pin levels, current motion, ready flag and
//   reject flag as they stand after that item.
//   cfg_we/cfg_wdata write the settle hold length; write only while idle.
//   An item passes the input register, then the result register; out_valid then
//   rises and the result transfer can happen. Throughput: one item per cycle
//   while the receiver does not stall, set by the single sequencer state
//   update per item.
//   Reset (rst_n low, synchronous): both stages empty, motors halted with all
//   pins low, block ready, settle length 500 ticks.
//   When the receiver stalls, the result holds and the input register takes
//   one more item, after which in_stall rises until the result is taken.
`default_nettype none

module dual_motor_turn_sequencer_core
  import dmts_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [15:0] in_turn_ticks,
  // result channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_right_fwd,
  output      logic        out_right_rev,
  output      logic        out_left_fwd,
  output      logic        out_left_rev,
  output      logic [2:0]  out_motion,
  output      logic        out_ready_res,
  output      logic        out_rejected
);

  item_t in_item, hold_item;
  logic  hold_valid;
  logic  adv, go;
  res_t  res, res_r;
  logic  out_valid_r, out_valid_nxt;

  assign in_item.cmd        = in_cmd;
  assign in_item.turn_ticks = in_turn_ticks;

  // Result register is free when empty or being taken
  assign adv = !out_valid_r || !out_stall;
  assign go  = hold_valid && adv;

  dmts_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  dmts_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (hold_item),
    .res       (res)
  );

  // Result register
  assign out_valid_nxt = adv ? hold_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_right_fwd = res_r.pins[3];
  assign out_right_rev = res_r.pins[2];
  assign out_left_fwd  = res_r.pins[1];
  assign out_left_rev  = res_r.pins[0];
  assign out_motion    = res_r.motion;
  assign out_ready_res = res_r.ready;
  assign out_rejected  = res_r.rejected;

endmodule

`default_nettype wire

// File: rtl/core/dmts_checker.sv
// Dual motor turn sequencer: port-level assertions and their bind to the top.
// Depends on dmts_pkg and dual_motor_turn_sequencer_core.
`default_nettype none

module dmts_checker
  import dmts_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_right_fwd,
  input wire logic       out_right_rev,
  input wire logic       out_left_fwd,
  input wire logic       out_left_rev,
  input wire logic [2:0] out_motion,
  input wire logic       out_ready_res,
  input wire logic       out_rejected
);

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motion)
      && $stable(out_ready_res) && $stable(out_rejected))
    else $error("result changed while stalled");

  // Synchronous reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A rejected command leaves the block busy
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_ready_res)
    else $error("rejected while ready");

  // Never drive both sides of one bridge
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_right_fwd && out_right_rev) && !(out_left_fwd && out_left_rev))
    else $error("bridge driven both ways");

  // Halted means all pins low
  a_halt_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion == MOT_HALTED) |->
      !out_right_fwd && !out_right_rev && !out_left_fwd && !out_left_rev)
    else $error("pins active while halted");

endmodule

bind dual_motor_turn_sequencer_core dmts_checker u_dmts_checker (.*);

`default_nettype wire

// File: tb/sv/dual_motor_turn_sequencer_core_tb.sv
// Self-checking bench for dual_motor_turn_sequencer_core: a tracking model checks
// every result transfer against its own copy of the sequencer state.
// Depends on dmts_pkg and the core RTL only.

module dual_motor_turn_sequencer_core_tb;
  import dmts_pkg::*;

  // Command codes outside the defined set; the core must ignore them
  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  // Random part: minimum input transfers per idling phase
  localparam int PHASE_ITEMS = 85;

  // Tracks motion, pins and countdown; holds the expected result queue
  class turn_sequencer_scoreboard;
    logic [15:0] settle_len;
    logic [2:0]  motion_now;
    logic [2:0]  motion_saved;
    phase_t      seq_phase;
    logic [15:0] count;
    logic [3:0]  pins;
    res_t        expected_q[$];
    int          errors;

    function new();
      settle_len   = SETTLE_RESET;
      motion_now   = MOT_HALTED;
      motion_saved = MOT_HALTED;
      seq_phase    = PH_IDLE;
      count        = '0;
      pins         = '0;
      errors       = 0;
    endfunction

    function bit is_ready();
      return seq_phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Pin bits {right_fwd, right_rev, left_fwd, left_rev}
    function void apply_motion(logic [2:0] m);
      motion_now = m;
      pins[3] = (m == MOT_FORWARD)  || (m == MOT_TURN_RT);
      pins[2] = (m == MOT_BACKWARD) || (m == MOT_TURN_LT);
      pins[1] = (m == MOT_FORWARD)  || (m == MOT_TURN_LT);
      pins[0] = (m == MOT_BACKWARD) || (m == MOT_TURN_RT);
    endfunction

    // 16-bit counts never exceed the count width, so no saturation here
    function void start_settle();
      count     = settle_len;
      seq_phase = (count == 0) ? PH_IDLE : PH_SETTLE;
    endfunction

    function void finish_turn();
      apply_motion(motion_saved);
      start_settle();
    endfunction

    // Advance the model by one accepted input and queue its result
    function void note_input(logic [2:0] code, logic [15:0] ticks);
      res_t exp;
      logic rej;
      rej = 1'b0;
      case (code)
        CMD_TICK: begin
          if (seq_phase != PH_IDLE) begin
            if (count != 0) count = count - 16'd1;
            if (count == 0) begin
              if (seq_phase == PH_TURN) finish_turn();
              else seq_phase = PH_IDLE;
            end
          end
        end
        // motion codes share the command code values
        CMD_FORWARD, CMD_BACKWARD, CMD_HALT: begin
          if (seq_phase != PH_IDLE) begin
            rej = 1'b1;
          end else begin
            apply_motion(code);
            start_settle();
          end
        end
        CMD_TURN_RT, CMD_TURN_LT: begin
          if (seq_phase != PH_IDLE) begin
            rej = 1'b1;
          end else begin
            motion_saved = motion_now;
            apply_motion(code);
            count = ticks;
            if (count == 0) finish_turn();
            else seq_phase = PH_TURN;
          end
        end
        default: ; // undefined codes leave everything as is
      endcase
      exp.pins     = pins;
      exp.motion   = motion_now;
      exp.ready    = (seq_phase == PH_IDLE);
      exp.rejected = rej;
      expected_q.push_back(exp);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task field_check(string name, logic [2:0] got, logic [2:0] exp);
      if (got !== exp) report($sformatf("%s got %0h expected %0h", name, got, exp));
    endtask

    // Compare one result transfer against the oldest expectation
    task check_result(res_t got);
      res_t exp;
      if (expected_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        exp = expected_q.pop_front();
        field_check("right_fwd", 3'(got.pins[3]), 3'(exp.pins[3]));
        field_check("right_rev", 3'(got.pins[2]), 3'(exp.pins[2]));
        field_check("left_fwd",  3'(got.pins[1]), 3'(exp.pins[1]));
        field_check("left_rev",  3'(got.pins[0]), 3'(exp.pins[0]));
        field_check("motion",    got.motion,      exp.motion);
        field_check("ready_res", 3'(got.ready),   3'(exp.ready));
        field_check("rejected",  3'(got.rejected), 3'(exp.rejected));
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [15:0] in_turn_ticks;
  logic        out_valid;
  logic        out_stall;
  logic        out_right_fwd;
  logic        out_right_rev;
  logic        out_left_fwd;
  logic        out_left_rev;
  logic [2:0]  out_motion;
  logic        out_ready_res;
  logic        out_rejected;

  turn_sequencer_scoreboard sb;
  res_t seen;
  int   snd_idle_pct;
  int   rcv_stall_pct;
  int   hold_left;
  int   items_sent;
  int   guard;
  int   ph;

  dual_motor_turn_sequencer_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_turn_ticks (in_turn_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_right_fwd (out_right_fwd),
    .out_right_rev (out_right_rev),
    .out_left_fwd  (out_left_fwd),
    .out_left_rev  (out_left_rev),
    .out_motion    (out_motion),
    .out_ready_res (out_ready_res),
    .out_rejected  (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: long hold-off when requested, otherwise random stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.pins     = {out_right_fwd, out_right_rev, out_left_fwd, out_left_rev};
      seen.motion   = out_motion;
      seen.ready    = out_ready_res;
      seen.rejected = out_rejected;
      sb.check_result(seen);
    end
  end

  // Offer one item, holding it until the transfer; the model follows at once
  task automatic send_item(input logic [2:0] code, input logic [15:0] ticks);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= code;
    in_turn_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(code, ticks);
    items_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Tick until the sequencer reports ready
  task automatic tick_until_ready();
    while (!sb.is_ready()) send_item(CMD_TICK, 16'($urandom));
  endtask

  // Change the settle length only with the sequencer ready and no results open
  task automatic write_settle(input logic [15:0] len);
    tick_until_ready();
    go_quiet();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.settle_len = len;
  endtask

  // Stray traffic: undefined codes, or commands that mostly land while busy
  task automatic send_noise();
    if ($urandom_range(0, 2) == 0)
      send_item(3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI)), 16'($urandom));
    else if (sb.is_ready())
      send_item(3'($urandom_range(CMD_FORWARD, CMD_TURN_LT)), 16'($urandom_range(0, 8)));
    else
      send_item(3'($urandom_range(CMD_FORWARD, CMD_TURN_LT)), 16'($urandom));
  endtask

  // One command followed by the ticks it needs; sometimes cut short or padded
  task automatic run_command_burst();
    logic [2:0]  code;
    logic [15:0] len;
    int n;
    int extra;
    int i;
    code = 3'($urandom_range(CMD_FORWARD, CMD_TURN_LT));
    len  = 16'($urandom_range(0, 8));
    n = int'(sb.settle_len);
    if (code == CMD_TURN_RT || code == CMD_TURN_LT) n += int'(len);
    send_item(code, len);
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
    extra = $urandom_range(0, 2);
    for (i = 0; i < n + extra; i++) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      send_item(CMD_TICK, 16'($urandom));
    end
  endtask

  // Run limit
  initial begin
    #40000000;
    $display("dual_motor_turn_sequencer_core_tb: errors");
    $finish;
  end

  // Main sequence
  initial begin
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_cmd        = CMD_TICK;
    in_turn_ticks = '0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    items_sent    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, default settle length: idle tick, undefined codes, busy rejects
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_UNDEF_LO, 16'hFFFF);
    send_item(CMD_UNDEF_HI, 16'h0000);
    send_item(CMD_FORWARD, 16'h0000);
    send_item(CMD_BACKWARD, 16'hFFFF);
    send_item(CMD_TURN_RT, 16'hFFFF);
    send_item(CMD_UNDEF_HI, 16'hFFFF);
    send_item(CMD_TICK, 16'hFFFF);
    tick_until_ready();

    // Zero settle: ready in the same transfer; zero and short turns
    write_settle(16'd0);
    send_item(CMD_HALT, 16'h0000);
    send_item(CMD_TURN_LT, 16'h0000);
    send_item(CMD_FORWARD, 16'h0000);
    send_item(CMD_TURN_RT, 16'd2);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_BACKWARD, 16'h0000);
    send_item(CMD_TURN_LT, 16'd1);
    send_item(CMD_TICK, 16'h0000);
    // longer turn, run to the end
    send_item(CMD_TURN_RT, 16'd24);
    tick_until_ready();

    // Longer settle hold
    write_settle(16'd40);
    send_item(CMD_FORWARD, 16'h0000);
    send_item(CMD_TURN_LT, 16'd5);
    tick_until_ready();

    // One-tick settle after a zero-length turn
    write_settle(16'd1);
    send_item(CMD_TURN_RT, 16'h0000);
    send_item(CMD_TICK, 16'h0000);

    // Random command bursts under each idling pattern
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 0;  rcv_stall_pct = 0;
          write_settle(16'($urandom_range(2, 5)));
          // long receiver hold-off while the sender keeps offering
          hold_left = 80;
        end
        1: begin
          snd_idle_pct = 88; rcv_stall_pct = 0;
          write_settle(16'd0);
        end
        2: begin
          snd_idle_pct = 0;  rcv_stall_pct = 88;
          write_settle(16'd1);
        end
        default: begin
          snd_idle_pct = 36; rcv_stall_pct = 36;
          write_settle(16'($urandom_range(0, 10)));
        end
      endcase
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) run_command_burst();
    end

    // Drain and finish
    go_quiet();
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0)
      $display("dual_motor_turn_sequencer_core_tb: clean");
    else
      $display("dual_motor_turn_sequencer_core_tb: errors");
    $finish;
  end

endmodule
